### src/vfd_pkg.sv
// shared types and constants of the velocity frame deframer
`default_nettype none

package vfd_pkg;

  localparam int unsigned FrameLen = 11;
  localparam int unsigned CheckPos = 9;
  localparam int unsigned TailPos  = 10;
  localparam int unsigned PosW     = $clog2(FrameLen);

  localparam logic [7:0] HeaderReset = 8'd125;
  localparam logic [7:0] TailReset   = 8'd123;
  localparam logic       CheckReset  = 1'b1;

  typedef enum logic [1:0] {
    CFG_HEADER = 2'd0,
    CFG_TAIL   = 2'd1,
    CFG_CHECK  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TAIL = 2'd1,
    STATUS_BAD_SUM  = 2'd2
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [7:0]         code_one;
    logic [7:0]         code_two;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [7:0]         check_byte;
  } result_t;

  typedef struct packed {
    logic    done;
    result_t result;
  } frame_out_t;

endpackage

`default_nettype wire

### src/velocity_frame_deframer_unit.sv
// top level of the velocity frame deframer
//
//   channel  signals                                   direction
//   cfg      cfg_valid_i cfg_ready_o cfg_index_i/data  in, always ready
//   in       in_valid_i in_ready_o rx_byte_i           in, one byte per transfer
//   out      out_valid_o out_ready_i status_o ...      out, one per 11-byte frame
//
// one byte per cycle while in_ready_o is high; the result register loads on the tail byte
// and shows the frame in the cycle after that byte's transfer
// reset returns to header hunt with the register defaults loaded
// in_ready_o drops only when the tail byte is due and the result register
// still holds an untaken frame
`default_nettype none

module velocity_frame_deframer_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [7:0]              code_one_o,
  output logic [7:0]              code_two_o,
  output logic signed [15:0]      vel_x_o,
  output logic signed [15:0]      vel_y_o,
  output logic signed [15:0]      vel_z_o,
  output logic [7:0]              check_byte_o
);

  logic [7:0]          header_q;
  logic [7:0]          tail_q;
  logic                check_en_q;
  logic                stall;
  vfd_pkg::frame_out_t frame;
  vfd_pkg::result_t    result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= vfd_pkg::HeaderReset;
      tail_q     <= vfd_pkg::TailReset;
      check_en_q <= vfd_pkg::CheckReset;
    end else if (cfg_valid_i) begin
      case (vfd_pkg::cfg_index_e'(cfg_index_i))
        vfd_pkg::CFG_HEADER: header_q   <= cfg_data_i;
        vfd_pkg::CFG_TAIL:   tail_q     <= cfg_data_i;
        vfd_pkg::CFG_CHECK:  check_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vfd_collector u_collector (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .header_byte_i  (header_q),
    .tail_byte_i    (tail_q),
    .check_enable_i (check_en_q),
    .out_stall_i    (stall),
    .frame_o        (frame)
  );

  vfd_result_reg u_result_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame),
    .stall_o     (stall),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign status_o     = result.status;
  assign code_one_o   = result.code_one;
  assign code_two_o   = result.code_two;
  assign vel_x_o      = result.vel_x;
  assign vel_y_o      = result.vel_y;
  assign vel_z_o      = result.vel_z;
  assign check_byte_o = result.check_byte;

endmodule

`default_nettype wire

### src/vfd_collector.sv
// header hunt, frame byte store, running xor and frame status
`default_nettype none

module vfd_collector (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [7:0]        header_byte_i,
  input  wire logic [7:0]        tail_byte_i,
  input  wire logic              check_enable_i,
  input  wire logic              out_stall_i,
  output vfd_pkg::frame_out_t    frame_o
);

  localparam logic [vfd_pkg::PosW-1:0] TailIdx =
    vfd_pkg::PosW'(vfd_pkg::TailPos);
  localparam logic [vfd_pkg::PosW-1:0] CheckIdx =
    vfd_pkg::PosW'(vfd_pkg::CheckPos);

  logic [vfd_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]               xor_q, xor_d;
  logic [7:0]               frame_q [1:vfd_pkg::CheckPos];
  logic                     accept;
  logic                     hunting;
  logic                     at_tail;
  vfd_pkg::status_e         status;

  assign hunting    = (pos_q == '0);
  assign at_tail    = (pos_q == TailIdx);
  assign in_ready_o = !(at_tail && out_stall_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pos_d = pos_q;
    xor_d = xor_q;
    if (accept) begin
      if (hunting) begin
        if (rx_byte_i == header_byte_i) begin
          pos_d = vfd_pkg::PosW'(1);
          xor_d = rx_byte_i;
        end
      end else if (at_tail) begin
        pos_d = '0;
        xor_d = '0;
      end else begin
        pos_d = pos_q + vfd_pkg::PosW'(1);
        if (pos_q < CheckIdx) begin
          xor_d = xor_q ^ rx_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      xor_q <= '0;
    end else begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 1; i <= vfd_pkg::CheckPos; i++) begin
      if (accept && pos_q == vfd_pkg::PosW'(i)) begin
        frame_q[i] <= rx_byte_i;
      end
    end
  end

  always_comb begin
    if (rx_byte_i != tail_byte_i) begin
      status = vfd_pkg::STATUS_BAD_TAIL;
    end else if (check_enable_i && xor_q != frame_q[vfd_pkg::CheckPos]) begin
      status = vfd_pkg::STATUS_BAD_SUM;
    end else begin
      status = vfd_pkg::STATUS_OK;
    end
  end

  always_comb begin
    frame_o.done              = accept && at_tail;
    frame_o.result.status     = status;
    frame_o.result.code_one   = frame_q[1];
    frame_o.result.code_two   = frame_q[2];
    frame_o.result.vel_x      = {frame_q[3], frame_q[4]};
    frame_o.result.vel_y      = {frame_q[5], frame_q[6]};
    frame_o.result.vel_z      = {frame_q[7], frame_q[8]};
    frame_o.result.check_byte = frame_q[vfd_pkg::CheckPos];
  end

endmodule

`default_nettype wire

### src/vfd_result_reg.sv
// result register holding one finished frame until transfer
`default_nettype none

module vfd_result_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire vfd_pkg::frame_out_t frame_i,
  output logic                     stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output vfd_pkg::result_t         result_o
);

  logic             valid_q, valid_d;
  vfd_pkg::result_t result_q;

  assign stall_o = valid_q && !out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (frame_i.done) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.done) begin
      result_q <= frame_i.result;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### src/vfd_checker.sv
// port-level checks for the velocity frame deframer, bound to the top level
`default_nettype none

module vfd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [1:0]         status_o,
  input wire logic [7:0]         code_one_o,
  input wire logic signed [15:0] vel_x_o
);

  // untaken result keeps valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(code_one_o) && $stable(vel_x_o))
    else $error("result changed before transfer");

  // status is a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == vfd_pkg::STATUS_OK
      || status_o == vfd_pkg::STATUS_BAD_TAIL
      || status_o == vfd_pkg::STATUS_BAD_SUM)
    else $error("undefined status code");

  // a new result only follows an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without input transfer");

  // input backpressure only while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

endmodule

bind velocity_frame_deframer_unit vfd_checker u_vfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .code_one_o  (code_one_o),
  .vel_x_o     (vel_x_o)
);

`default_nettype wire
